/* sv/cv3_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cv3_pkg;

  localparam int MAX_WIDTH     = 1024;
  localparam int MAX_HEIGHT    = 1024;
  localparam int PIXEL_BITS    = 8;
  localparam int COEF_BITS     = 8;
  localparam int OUT_BITS      = 20;

  // Frame size registers and the clamped sizes derived from them.
  localparam int DIM_BITS      = 11;
  localparam int COL_BITS      = $clog2(MAX_WIDTH);
  localparam int OROW_BITS     = $clog2(MAX_HEIGHT);
  // The input row runs on up to two rows past the frame while draining.
  localparam int IROW_BITS     = $clog2(MAX_HEIGHT + 3);

  localparam int KERN_BITS     = 3 * COEF_BITS;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 24;

  // Signed coefficient times unsigned pixel, then sums of three and of nine.
  localparam int PROD_BITS     = COEF_BITS + PIXEL_BITS + 1;
  localparam int ROW_SUM_BITS  = PROD_BITS + 2;

  localparam logic [KERN_BITS-1:0] KERN_MID_RESET = KERN_BITS'(1) << (2 * COEF_BITS);
  localparam logic [DIM_BITS-1:0]  WIDTH_RESET    = DIM_BITS'(MAX_WIDTH);
  localparam logic [DIM_BITS-1:0]  HEIGHT_RESET   = DIM_BITS'(MAX_HEIGHT);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_KERNEL_TOP    = 3'd0,
    REG_KERNEL_MIDDLE = 3'd1,
    REG_KERNEL_BOTTOM = 3'd2,
    REG_FRAME_WIDTH   = 3'd3,
    REG_FRAME_HEIGHT  = 3'd4
  } cfg_reg_t;

endpackage

`default_nettype wire

/* sv/cv3_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface cv3_in_if import cv3_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic                  operation;
  logic [PIXEL_BITS-1:0] pixel;

  modport source (output valid, output operation, output pixel, input ready);
  modport sink   (input valid, input operation, input pixel, output ready);
endinterface

`default_nettype wire

/* sv/cv3_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface cv3_out_if import cv3_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] filtered;
  logic                       last;

  modport source (output valid, output filtered, output last, input ready);
  modport sink   (input valid, input filtered, input last, output ready);
endinterface

`default_nettype wire

/* sv/cv3_cfg_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface cv3_cfg_if import cv3_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* sv/conv3x3_replicate_border.sv */
// 3x3 convolution over a raster-order pixel stream, border pixels replicated.
//
// in_bus carries one beat per item: a pixel of the frame (operation 0) or a
// flush item (operation 1). After the last pixel of a frame the source sends
// frame_width + 1 flush beats so that the bottom row drains. out_bus carries
// one beat per output pixel: the signed sum of the nine coefficient-pixel
// products and a last flag on the final pixel of the frame. The first
// frame_width + 1 items of a frame give no result; after that each item gives
// the result for the pixel frame_width + 1 places earlier. cfg_bus writes the
// kernel rows and the frame size; it is always ready. The user must write it
// only while no item is in flight; the block itself does not enforce this.
// Throughput is one item per clock unless out_bus stalls. A result reaches
// out_bus through the line-store read, selection, multiplier and two adder
// stages. Both line stores share one RAM that is read and written back once
// per item; a bypass covers back-to-back items at the same column.
// When out_bus stalls, results collect in the pipeline and in_bus keeps
// taking beats until every stage holds one; then in_bus.ready drops.
// Reset restores the power-on kernel (a copy of each pixel's right neighbor)
// and a 1024 x 1024 frame, and restarts the frame. The line stores are not
// cleared: replicated borders keep unwritten entries out of every sum.
`timescale 1ns / 1ps
`default_nettype none

module conv3x3_replicate_border import cv3_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cv3_in_if.sink     in_bus,
  cv3_out_if.source  out_bus,
  cv3_cfg_if.sink    cfg_bus
);

  // Item as it leaves the counter stage and waits for the line-store read.
  typedef struct packed {
    logic [PIXEL_BITS-1:0] px;
    logic [COL_BITS-1:0]   col;
    logic                  produce;
    logic                  top;
    logic                  bottom;
    logic                  left;
    logic                  right;
    logic                  last;
  } s1_t;

  // ---------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------
  logic [2:0][KERN_BITS-1:0] kern_r;
  logic [DIM_BITS-1:0]       fw_r;
  logic [DIM_BITS-1:0]       fh_r;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kern_r[0] <= '0;
      kern_r[1] <= KERN_MID_RESET;
      kern_r[2] <= '0;
      fw_r      <= WIDTH_RESET;
      fh_r      <= HEIGHT_RESET;
    end else if (cfg_bus.valid) begin
      case (cfg_reg_t'(cfg_bus.index))
        REG_KERNEL_TOP:    kern_r[0] <= cfg_bus.data[KERN_BITS-1:0];
        REG_KERNEL_MIDDLE: kern_r[1] <= cfg_bus.data[KERN_BITS-1:0];
        REG_KERNEL_BOTTOM: kern_r[2] <= cfg_bus.data[KERN_BITS-1:0];
        REG_FRAME_WIDTH:   fw_r      <= cfg_bus.data[DIM_BITS-1:0];
        REG_FRAME_HEIGHT:  fh_r      <= cfg_bus.data[DIM_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Frame size in use: zero counts as one, anything above the maximum as the
  // maximum.
  logic [DIM_BITS-1:0] wc;
  logic [DIM_BITS-1:0] hc;

  always_comb begin
    if (fw_r == '0) begin
      wc = DIM_BITS'(1);
    end else if (fw_r > DIM_BITS'(MAX_WIDTH)) begin
      wc = DIM_BITS'(MAX_WIDTH);
    end else begin
      wc = fw_r;
    end
    if (fh_r == '0) begin
      hc = DIM_BITS'(1);
    end else if (fh_r > DIM_BITS'(MAX_HEIGHT)) begin
      hc = DIM_BITS'(MAX_HEIGHT);
    end else begin
      hc = fh_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control. Each stage moves when the stage after it is empty
  // or moving, so bubbles collapse and input keeps flowing under a stall.
  // ---------------------------------------------------------------------------
  logic s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, out_valid_r;
  s1_t  s1_r;
  logic take_out, take4, take3, take2, adv1, accept;

  assign take_out = !out_valid_r || out_bus.ready;
  assign take4    = !s4_valid_r || take_out;
  assign take3    = !s3_valid_r || take4;
  assign take2    = !s2_valid_r || take3;
  // An item that gives no result leaves stage 1 without needing room behind it.
  assign adv1     = s1_valid_r && (!s1_r.produce || take2);
  assign in_bus.ready = !s1_valid_r || adv1;
  assign accept   = in_bus.valid && in_bus.ready;

  // ---------------------------------------------------------------------------
  // Position counters, updated on every accepted beat.
  // ---------------------------------------------------------------------------
  logic [IROW_BITS-1:0] in_row_r, in_row_nxt;
  logic [COL_BITS-1:0]  in_col_r, in_col_nxt;
  logic [OROW_BITS-1:0] out_row_r, out_row_nxt;
  logic [COL_BITS-1:0]  out_col_r, out_col_nxt;
  s1_t                  s1_nxt;

  logic                 draining;
  logic [DIM_BITS-1:0]  in_col_inc;
  logic [DIM_BITS-1:0]  out_col_inc;
  logic [DIM_BITS-1:0]  out_row_inc;

  always_comb begin
    draining    = in_row_r >= IROW_BITS'(hc);
    in_col_inc  = DIM_BITS'(in_col_r) + DIM_BITS'(1);
    out_col_inc = DIM_BITS'(out_col_r) + DIM_BITS'(1);
    out_row_inc = DIM_BITS'(out_row_r) + DIM_BITS'(1);

    // A flush beat, or any beat after the frame's last pixel, feeds zero.
    s1_nxt.px      = (in_bus.operation || draining) ? '0 : in_bus.pixel;
    s1_nxt.col     = in_col_r;
    // The window is full once the raster position reaches width + 1.
    s1_nxt.produce = (in_row_r >= IROW_BITS'(2))
                  || ((in_row_r == IROW_BITS'(1)) && (in_col_r != '0))
                  || ((in_row_r == '0) && (DIM_BITS'(in_col_r) > wc));
    s1_nxt.top     = (out_row_r == '0);
    s1_nxt.bottom  = (out_row_inc >= hc);
    s1_nxt.left    = (out_col_r == '0);
    s1_nxt.right   = (out_col_inc >= wc);
    s1_nxt.last    = s1_nxt.bottom && s1_nxt.right;

    in_row_nxt  = in_row_r;
    in_col_nxt  = in_col_inc[COL_BITS-1:0];
    out_row_nxt = out_row_r;
    out_col_nxt = out_col_r;

    if (in_col_inc >= wc) begin
      in_col_nxt = '0;
      if (in_row_r <= IROW_BITS'(hc) + IROW_BITS'(1)) begin
        in_row_nxt = in_row_r + IROW_BITS'(1);
      end
    end

    if (s1_nxt.produce) begin
      if (s1_nxt.last) begin
        // End of frame: the next beat is the first pixel of a new frame.
        in_row_nxt  = '0;
        in_col_nxt  = '0;
        out_row_nxt = '0;
        out_col_nxt = '0;
      end else if (s1_nxt.right) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + OROW_BITS'(1);
      end else begin
        out_col_nxt = out_col_inc[COL_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_row_r  <= '0;
      in_col_r  <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
    end else if (accept) begin
      in_row_r  <= in_row_nxt;
      in_col_r  <= in_col_nxt;
      out_row_r <= out_row_nxt;
      out_col_r <= out_col_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Line stores: one RAM word holds the upper and middle line pixels of a
  // column. The column is read when the beat is accepted, and the item writes
  // back {old middle, new pixel} as it leaves stage 1.
  // ---------------------------------------------------------------------------
  localparam int LINE_BITS = 2 * PIXEL_BITS;

  logic [LINE_BITS-1:0]  ram_rdata;
  logic [LINE_BITS-1:0]  ram_wdata;
  logic [LINE_BITS-1:0]  line_rd;
  logic                  fwd_r;
  logic [LINE_BITS-1:0]  fwd_data_r;
  logic [PIXEL_BITS-1:0] up_px, mid_px;

  cv3_ram #(
    .WIDTH (LINE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (adv1),
    .waddr (s1_r.col),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (in_col_r),
    .rdata (ram_rdata)
  );

  // The RAM returns old data when the previous item writes the same column in
  // the cycle of the read, so that write is carried over in a register.
  assign line_rd   = fwd_r ? fwd_data_r : ram_rdata;
  assign up_px     = line_rd[LINE_BITS-1:PIXEL_BITS];
  assign mid_px    = line_rd[PIXEL_BITS-1:0];
  assign ram_wdata = {mid_px, s1_r.px};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r      <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        fwd_r      <= s1_valid_r && (s1_r.col == in_col_r);
        s1_valid_r <= 1'b1;
      end else if (adv1) begin
        fwd_r      <= 1'b0;
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r       <= s1_nxt;
      fwd_data_r <= ram_wdata;
    end
  end

  // ---------------------------------------------------------------------------
  // 3x3 window, indexed [row][column]; column 2 is the newest.
  // ---------------------------------------------------------------------------
  logic [2:0][2:0][PIXEL_BITS-1:0] win_r, win_nxt, vsel;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r][0] = win_r[r][1];
      win_nxt[r][1] = win_r[r][2];
    end
    win_nxt[0][2] = up_px;
    win_nxt[1][2] = mid_px;
    win_nxt[2][2] = s1_r.px;

    // Border replication: rows first, then columns of the result.
    vsel = win_nxt;
    if (s1_r.top) begin
      vsel[0] = vsel[1];
    end
    if (s1_r.bottom) begin
      vsel[2] = vsel[1];
    end
    for (int r = 0; r < 3; r++) begin
      if (s1_r.left) begin
        vsel[r][0] = vsel[r][1];
      end
      if (s1_r.right) begin
        vsel[r][2] = vsel[r][1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (adv1) begin
      win_r <= win_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: selected neighborhood. Stage 3: nine products. Stage 4: row sums.
  // Output register: the full sum.
  // ---------------------------------------------------------------------------
  logic [2:0][2:0][PIXEL_BITS-1:0]             v_r;
  logic                                         s2_last_r;
  logic signed [PROD_BITS-1:0]                  prod_r    [3][3];
  logic signed [PROD_BITS-1:0]                  prod_nxt  [3][3];
  logic                                         s3_last_r;
  logic signed [ROW_SUM_BITS-1:0]               rsum_r    [3];
  logic signed [ROW_SUM_BITS-1:0]               rsum_nxt  [3];
  logic                                         s4_last_r;
  logic signed [OUT_BITS-1:0]                   filtered_r, filtered_nxt;
  logic                                         last_r;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_nxt[r][c] = $signed(kern_r[r][c*COEF_BITS +: COEF_BITS])
                       * $signed({1'b0, v_r[r][c]});
      end
    end
    for (int r = 0; r < 3; r++) begin
      rsum_nxt[r] = ROW_SUM_BITS'(prod_r[r][0]) + ROW_SUM_BITS'(prod_r[r][1])
                  + ROW_SUM_BITS'(prod_r[r][2]);
    end
    filtered_nxt = OUT_BITS'(rsum_r[0]) + OUT_BITS'(rsum_r[1]) + OUT_BITS'(rsum_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take2) begin
        s2_valid_r <= adv1 && s1_r.produce;
      end
      if (take3) begin
        s3_valid_r <= s2_valid_r;
      end
      if (take4) begin
        s4_valid_r <= s3_valid_r;
      end
      if (take_out) begin
        out_valid_r <= s4_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take2 && adv1) begin
      v_r       <= vsel;
      s2_last_r <= s1_r.last;
    end
    if (take3 && s2_valid_r) begin
      prod_r    <= prod_nxt;
      s3_last_r <= s2_last_r;
    end
    if (take4 && s3_valid_r) begin
      rsum_r    <= rsum_nxt;
      s4_last_r <= s3_last_r;
    end
    if (take_out && s4_valid_r) begin
      filtered_r <= filtered_nxt;
      last_r     <= s4_last_r;
    end
  end

  assign out_bus.valid    = out_valid_r;
  assign out_bus.filtered = filtered_r;
  assign out_bus.last     = last_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------

  // Two back-to-back items on the same column must use the bypass.
  a_bypass_set: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && s1_valid_r && (s1_r.col == in_col_r)) |=> fwd_r)
    else $error("line store bypass not armed for a same-column read");

  // The bypass only ever refers to the item waiting in stage 1.
  a_bypass_owner: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> s1_valid_r)
    else $error("line store bypass armed with stage 1 empty");

  // The last result of a frame restarts every position counter.
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && s1_nxt.produce && s1_nxt.last) |=>
      (in_row_r == '0) && (in_col_r == '0) && (out_row_r == '0) && (out_col_r == '0))
    else $error("counters not cleared at end of frame");

  // A held result must not be overwritten by a later one.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_bus.ready) |=> (out_valid_r && $stable(filtered_r)))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

/* sv/cv3_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
// A read of the address being written in the same cycle returns the old data.
module cv3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import cv3_pkg::*;

  // Operation codes carried in the operation field of an input beat.
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam int RANDOM_BEATS = 800;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 400000;
  // Neither side idles inside this window, so the block also sees long
  // stretches of back-to-back beats.
  localparam int CALM_START = 2000;
  localparam int CALM_END = 4500;

  typedef struct packed {
    logic                  op;
    logic [PIXEL_BITS-1:0] pixel;
  } pixel_beat_t;

  typedef struct {
    logic signed [OUT_BITS-1:0] filtered;
    logic                       last;
  } conv_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #1 clk = ~clk;

  cv3_in_if  in_bus ();
  cv3_out_if out_bus ();
  cv3_cfg_if cfg_bus ();

  // Every input of the block is driven from these, so all of them are known
  // from time zero.
  logic                     in_valid = 1'b0;
  pixel_beat_t              beat_on_bus = '0;
  logic                     out_ready = 1'b0;
  logic                     cfg_valid = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  assign in_bus.valid     = in_valid;
  assign in_bus.operation = beat_on_bus.op;
  assign in_bus.pixel     = beat_on_bus.pixel;
  assign out_bus.ready    = out_ready;
  assign cfg_bus.valid    = cfg_valid;
  assign cfg_bus.index    = cfg_index;
  assign cfg_bus.data     = cfg_data;

  conv3x3_replicate_border DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  // Mirror of the configuration registers, updated on each accepted write.
  logic [KERN_BITS-1:0] coef_top = '0;
  logic [KERN_BITS-1:0] coef_mid = KERN_MID_RESET;
  logic [KERN_BITS-1:0] coef_bot = '0;
  logic [DIM_BITS-1:0]  width_reg = WIDTH_RESET;
  logic [DIM_BITS-1:0]  height_reg = HEIGHT_RESET;

  // Predictor state: two line stores that hold the last two rows column by
  // column, the 3x3 neighborhood taps, and the position of the next input
  // beat and of the next output pixel.
  logic [PIXEL_BITS-1:0] older_line [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] newer_line [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] tap [3][3];
  int feed_row = 0;
  int feed_col = 0;
  int emit_row = 0;
  int emit_col = 0;

  pixel_beat_t  pixel_queue [$];
  conv_result_t pending_sums [$];
  int beats_queued = 0;
  int fail_count = 0;
  int cycle_count = 0;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  function automatic bit take_break();
    if (cycle_count >= CALM_START && cycle_count < CALM_END) return 1'b0;
    return $urandom_range(99) < 31;
  endfunction

  // A size register of zero means one, and anything above the maximum means
  // the maximum.
  function automatic int clamp_size(logic [DIM_BITS-1:0] v, int maxv);
    if (v == 0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic int coef_at(logic [KERN_BITS-1:0] row, int pos);
    logic signed [COEF_BITS-1:0] c;
    c = row[pos*COEF_BITS +: COEF_BITS];
    return int'(c);
  endfunction

  // Advances the predictor by one accepted input beat and queues the output
  // pixel that the beat completes, if any. Outputs trail the input by
  // width + 1 beats, so the first width + 1 beats of a frame give nothing.
  task automatic convolve_beat(input pixel_beat_t beat);
    int w;
    int h;
    int col;
    int pos;
    int sum;
    logic [PIXEL_BITS-1:0] p;
    logic [PIXEL_BITS-1:0] up;
    logic [PIXEL_BITS-1:0] mid;
    logic [PIXEL_BITS-1:0] v [3][3];
    conv_result_t res;
    w = clamp_size(width_reg, MAX_WIDTH);
    h = clamp_size(height_reg, MAX_HEIGHT);
    p = beat.pixel;
    // A flush inside the frame counts as a black pixel; once the last row is
    // in, every beat is a flush whatever its operation says.
    if (beat.op == OP_FLUSH || feed_row >= h) p = '0;
    col = feed_col % MAX_WIDTH;
    up = older_line[col];
    mid = newer_line[col];
    older_line[col] = mid;
    newer_line[col] = p;
    for (int r = 0; r < 3; r++) begin
      tap[r][0] = tap[r][1];
      tap[r][1] = tap[r][2];
    end
    tap[0][2] = up;
    tap[1][2] = mid;
    tap[2][2] = p;
    pos = feed_row * w + feed_col;
    feed_col++;
    if (feed_col >= w) begin
      feed_col = 0;
      if (feed_row <= h + 1) feed_row++;
    end
    if (pos >= w + 1) begin
      v = tap;
      // Replicate the edge row or column wherever the neighborhood runs off
      // the frame.
      if (emit_row == 0) for (int c = 0; c < 3; c++) v[0][c] = v[1][c];
      if (emit_row + 1 >= h) for (int c = 0; c < 3; c++) v[2][c] = v[1][c];
      if (emit_col == 0) for (int r = 0; r < 3; r++) v[r][0] = v[r][1];
      if (emit_col + 1 >= w) for (int r = 0; r < 3; r++) v[r][2] = v[r][1];
      sum = 0;
      for (int c = 0; c < 3; c++) begin
        sum += coef_at(coef_top, c) * int'(v[0][c]);
        sum += coef_at(coef_mid, c) * int'(v[1][c]);
        sum += coef_at(coef_bot, c) * int'(v[2][c]);
      end
      res.filtered = OUT_BITS'(sum);
      res.last = (emit_row + 1 >= h) && (emit_col + 1 >= w);
      pending_sums.push_back(res);
      if (res.last) begin
        // The frame is done: the next beat starts a fresh one.
        feed_row = 0;
        feed_col = 0;
        emit_row = 0;
        emit_col = 0;
      end else begin
        emit_col++;
        if (emit_col >= w) begin
          emit_col = 0;
          emit_row++;
        end
      end
    end
  endtask

  // Input driver: takes the next pending beat whenever the bus is free or the
  // current beat was accepted, with random gaps in between.
  always @(posedge clk) begin : input_driver
    pixel_beat_t next_beat;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_bus.ready) convolve_beat(beat_on_bus);
      if (!in_valid || in_bus.ready) begin
        if (pixel_queue.size() != 0 && !take_break()) begin
          next_beat = pixel_queue.pop_front();
          beat_on_bus <= next_beat;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: compares each accepted result beat with the oldest
  // prediction and stalls the block at random.
  always @(posedge clk) begin : result_monitor
    conv_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_ready) begin
        if (pending_sums.size() == 0) begin
          $error("filtered: result with no expectation, got %0d", out_bus.filtered);
          fail_count++;
        end else begin
          want = pending_sums.pop_front();
          if (out_bus.filtered !== want.filtered) begin
            $error("filtered: expected %0d, got %0d", want.filtered, out_bus.filtered);
            fail_count++;
          end
          if (out_bus.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_bus.last);
            fail_count++;
          end
        end
      end
      out_ready <= !take_break();
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  task automatic push_beat(input logic op, input logic [PIXEL_BITS-1:0] px);
    pixel_queue.push_back('{op: op, pixel: px});
    beats_queued++;
  endtask

  function automatic logic [PIXEL_BITS-1:0] random_pixel();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return PIXEL_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [KERN_BITS-1:0] random_kernel();
    case ($urandom_range(5))
      0: return 24'h808080;
      1: return 24'h7F7F7F;
      2: return '0;
      default: return KERN_BITS'($urandom);
    endcase
  endfunction

  // Queues one whole frame: w * h beats for the pixels, then the w + 1 beats
  // that drain the bottom row. Some beats carry the other operation; a noisy
  // frame mixes them evenly, which the block must handle beat by beat.
  task automatic queue_frame(input int w, input int h, input bit noisy);
    logic op;
    for (int i = 0; i < w * h; i++) begin
      if (noisy) op = ($urandom_range(1) == 0) ? OP_PIXEL : OP_FLUSH;
      else op = ($urandom_range(19) == 0) ? OP_FLUSH : OP_PIXEL;
      push_beat(op, random_pixel());
    end
    for (int i = 0; i <= w; i++) begin
      if (noisy) op = ($urandom_range(1) == 0) ? OP_PIXEL : OP_FLUSH;
      else op = ($urandom_range(9) == 0) ? OP_PIXEL : OP_FLUSH;
      push_beat(op, random_pixel());
    end
  endtask

  // Returns once every queued beat has gone in and every predicted result
  // has come out, and then lets the beats that give no result settle.
  task automatic wait_quiet();
    while (pixel_queue.size() != 0 || in_valid || pending_sums.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    case (idx)
      REG_KERNEL_TOP:    coef_top = val[KERN_BITS-1:0];
      REG_KERNEL_MIDDLE: coef_mid = val[KERN_BITS-1:0];
      REG_KERNEL_BOTTOM: coef_bot = val[KERN_BITS-1:0];
      REG_FRAME_WIDTH:   width_reg = val[DIM_BITS-1:0];
      REG_FRAME_HEIGHT:  height_reg = val[DIM_BITS-1:0];
      default: ;
    endcase
  endtask

  // All five registers are rewritten at every change of settings, and only
  // while the block is quiet between frames.
  task automatic load_settings(input logic [KERN_BITS-1:0] top,
                               input logic [KERN_BITS-1:0] mid,
                               input logic [KERN_BITS-1:0] bot,
                               input logic [DIM_BITS-1:0] wd,
                               input logic [DIM_BITS-1:0] ht);
    wait_quiet();
    write_reg(REG_KERNEL_TOP, CFG_DATA_BITS'(top));
    write_reg(REG_KERNEL_MIDDLE, CFG_DATA_BITS'(mid));
    write_reg(REG_KERNEL_BOTTOM, CFG_DATA_BITS'(bot));
    write_reg(REG_FRAME_WIDTH, CFG_DATA_BITS'(wd));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_BITS'(ht));
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int start;
    logic [DIM_BITS-1:0] wr;
    logic [DIM_BITS-1:0] hr;
    foreach (older_line[i]) begin
      older_line[i] = '0;
      newer_line[i] = '0;
    end
    foreach (tap[r, c]) tap[r][c] = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Every coefficient at -128 on a 3x2 frame. The corner pixel sees only
    // full-scale neighbors, which gives the most negative sum. The frame also
    // carries a flush in place of its last pixel and a pixel beat while
    // draining.
    load_settings(24'h808080, 24'h808080, 24'h808080, 11'd3, 11'd2);
    push_beat(OP_PIXEL, 8'd255);
    push_beat(OP_PIXEL, 8'd255);
    push_beat(OP_PIXEL, 8'd0);
    push_beat(OP_PIXEL, 8'd255);
    push_beat(OP_PIXEL, 8'd255);
    push_beat(OP_FLUSH, 8'd255);
    push_beat(OP_FLUSH, 8'd0);
    push_beat(OP_FLUSH, 8'd0);
    push_beat(OP_PIXEL, 8'd255);
    push_beat(OP_FLUSH, 8'd0);

    // Zero width and height both mean a single pixel; every coefficient at
    // +127 gives the largest sum. The second one-pixel frame has only a flush
    // beat for its pixel.
    load_settings(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, 11'd0, 11'd0);
    push_beat(OP_PIXEL, 8'd255);
    push_beat(OP_FLUSH, 8'd0);
    push_beat(OP_FLUSH, 8'd0);
    push_beat(OP_FLUSH, 8'hAA);
    push_beat(OP_PIXEL, 8'h55);
    push_beat(OP_FLUSH, 8'd0);

    // Mixed signs with the power-on middle row, on a 2x3 frame.
    load_settings(24'h01FF80, KERN_MID_RESET, 24'h7F0180, 11'd2, 11'd3);
    push_beat(OP_PIXEL, 8'h55);
    push_beat(OP_PIXEL, 8'hAA);
    push_beat(OP_PIXEL, 8'h01);
    push_beat(OP_PIXEL, 8'hFE);
    push_beat(OP_PIXEL, 8'h80);
    push_beat(OP_PIXEL, 8'h7F);
    push_beat(OP_FLUSH, 8'd0);
    push_beat(OP_FLUSH, 8'd0);
    push_beat(OP_FLUSH, 8'd0);

    // An oversized height clamps to the maximum, run once on a frame that is
    // a single column.
    load_settings(random_kernel(), random_kernel(), random_kernel(), 11'd0, 11'd2047);
    queue_frame(1, MAX_HEIGHT, 1'b0);

    // Random settings, each for a few small frames.
    start = beats_queued;
    while (beats_queued - start < RANDOM_BEATS) begin
      case ($urandom_range(9))
        0: wr = '0;
        1: wr = 11'd1;
        default: wr = DIM_BITS'($urandom_range(2, 12));
      endcase
      hr = ($urandom_range(9) == 0) ? '0 : DIM_BITS'($urandom_range(1, 6));
      load_settings(random_kernel(), random_kernel(), random_kernel(), wr, hr);
      repeat ($urandom_range(1, 3))
        queue_frame(clamp_size(wr, MAX_WIDTH), clamp_size(hr, MAX_HEIGHT),
                    $urandom_range(9) >= 8);
    end

    wait_quiet();
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
